[sv/sd_spi_init_sequencer_assert.svh]
// Assertion macros for the SD card SPI init sequencer.
// Included by the top level; no other dependencies.
`ifndef SD_SPI_INIT_SEQUENCER_ASSERT_SVH
`define SD_SPI_INIT_SEQUENCER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SDSPI_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sdspi: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define SDSPI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sdspi: next-cycle check failed");

`endif

[sv/sdspi_pkg.sv]
// Shared types, constants and frame functions for the SD card SPI init sequencer.
// No dependencies.
`default_nettype none

package sdspi_pkg;

   localparam int PREAMBLE_BYTES_DEFAULT = 10;
   localparam int RESPONSE_DEPTH_DEFAULT = 5;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;
   localparam int FRAME_IDX_W = 3;
   localparam int CMD_LEN_W  = 3;

   localparam logic [7:0] POLL_LIMIT_RESET  = 8'd100;
   localparam logic [7:0] RETRY_LIMIT_RESET = 8'd100;
   localparam logic       HCS_RESET         = 1'b1;

   localparam logic [7:0]  BYTE_FILL    = 8'hFF;
   localparam logic [7:0]  CMD_START    = 8'h40;
   localparam logic [7:0]  CRC_CMD0     = 8'h95;
   localparam logic [7:0]  CRC_CMD8     = 8'h87;
   localparam logic [7:0]  CRC_OTHER    = 8'h01;
   localparam logic [31:0] CMD8_ARG     = 32'h0000_01AA;
   localparam logic [31:0] HCS_ARG      = 32'h4000_0000;
   localparam logic [7:0]  R1_IDLE      = 8'h01;
   localparam logic [7:0]  R1_READY     = 8'h00;
   localparam logic [7:0]  VOLT_ACCEPT  = 8'h01;
   localparam logic [7:0]  OCR_VOLT_MASK = 8'h30;
   localparam logic [7:0]  OCR_CCS_MASK  = 8'hC0;
   localparam int          FRAME_LAST   = 5;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_POLL_LIMIT  = 2'd0,
      CSR_RETRY_LIMIT = 2'd1,
      CSR_HCS         = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PRE,
      ST_SEND,
      ST_POLL,
      ST_COLLECT,
      ST_TRAIL
   } seq_state_type;

   typedef enum logic [2:0] {
      SLOT_CMD0       = 3'd0,
      SLOT_CMD8       = 3'd1,
      SLOT_CMD58_OCR  = 3'd2,
      SLOT_CMD55      = 3'd3,
      SLOT_ACMD41     = 3'd4,
      SLOT_CMD58_LAST = 3'd5
   } cmd_slot_type;

   typedef enum logic [2:0] {
      STATUS_OK       = 3'd0,
      STATUS_TIMEOUT  = 3'd1,
      STATUS_BAD_R1   = 3'd2,
      STATUS_VOLTAGE  = 3'd3,
      STATUS_STUCK    = 3'd4,
      STATUS_IDLE_END = 3'd5,
      STATUS_CAPACITY = 3'd6
   } status_type;

   typedef struct packed {
      logic [7:0] poll_limit;
      logic [7:0] retry_limit;
      logic       hcs;
   } cfg_type;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       tx_enable;
      logic       chip_select_n;
      logic       finished;
      logic [2:0] status;
      logic [7:0] offending_response;
   } result_type;

   // Command index with the start/transmission bits set.
   function automatic logic [7:0] cmd_code(cmd_slot_type slot);
      logic [7:0] code;
      case (slot)
         SLOT_CMD0:   code = CMD_START | 8'd0;
         SLOT_CMD8:   code = CMD_START | 8'd8;
         SLOT_CMD55:  code = CMD_START | 8'd55;
         SLOT_ACMD41: code = CMD_START | 8'd41;
         default:     code = CMD_START | 8'd58;
      endcase
      return code;
   endfunction

   function automatic logic [7:0] cmd_crc(cmd_slot_type slot);
      logic [7:0] crc;
      case (slot)
         SLOT_CMD0: crc = CRC_CMD0;
         SLOT_CMD8: crc = CRC_CMD8;
         default:   crc = CRC_OTHER;
      endcase
      return crc;
   endfunction

   // Response length in bytes: R1 alone, or R1 plus four (R7/R3).
   function automatic logic [CMD_LEN_W-1:0] cmd_len(cmd_slot_type slot);
      logic [CMD_LEN_W-1:0] len;
      case (slot)
         SLOT_CMD8, SLOT_CMD58_OCR, SLOT_CMD58_LAST: len = 3'd5;
         default:                                    len = 3'd1;
      endcase
      return len;
   endfunction

   // Byte b of the six-byte command frame.
   function automatic logic [7:0] frame_byte(cmd_slot_type slot,
                                             logic [FRAME_IDX_W-1:0] b, logic hcs);
      logic [31:0] arg;
      logic [7:0]  value;
      arg = '0;
      if (slot == SLOT_CMD8) begin
         arg = CMD8_ARG;
      end
      if (slot == SLOT_ACMD41 && hcs) begin
         arg = HCS_ARG;
      end
      case (b)
         3'd0:    value = cmd_code(slot);
         3'd1:    value = arg[31:24];
         3'd2:    value = arg[23:16];
         3'd3:    value = arg[15:8];
         3'd4:    value = arg[7:0];
         default: value = cmd_crc(slot);
      endcase
      return value;
   endfunction

endpackage

`default_nettype wire

[sv/sdspi_if.sv]
// Handshake channel interfaces for the SD card SPI init sequencer.
// Depends on sdspi_pkg for widths.
`default_nettype none

interface sdspi_req_if;
   logic       valid;
   logic       ready;
   logic       start_request;
   logic [7:0] rx_byte;

   modport source (output valid, start_request, rx_byte, input ready);
   modport sink (input valid, start_request, rx_byte, output ready);
endinterface

interface sdspi_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] tx_byte;
   logic       tx_enable;
   logic       chip_select_n;
   logic       finished;
   logic [2:0] status;
   logic [7:0] offending_response;

   modport source (output valid, tx_byte, tx_enable, chip_select_n, finished, status,
                   offending_response, input ready);
   modport sink (input valid, tx_byte, tx_enable, chip_select_n, finished, status,
                 offending_response, output ready);
endinterface

interface sdspi_csr_if;
   logic                             valid;
   logic                             ready;
   logic [sdspi_pkg::CSR_IDX_W-1:0]  index;
   logic [sdspi_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[sv/sdspi_cfg.sv]
// Configuration registers of the SD card SPI init sequencer.
// Depends on sdspi_pkg and sdspi_csr_if.
`default_nettype none

module sdspi_cfg (
   input  wire logic          clock,
   input  wire logic          reset,
   sdspi_csr_if.sink          csr_ch,
   output sdspi_pkg::cfg_type cfg
);

   sdspi_pkg::cfg_type cfg_ff;
   sdspi_pkg::cfg_type cfg_in;

   assign csr_ch.ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         unique case (sdspi_pkg::csr_index_type'(csr_ch.index))
            sdspi_pkg::CSR_POLL_LIMIT:  cfg_in.poll_limit  = csr_ch.data;
            sdspi_pkg::CSR_RETRY_LIMIT: cfg_in.retry_limit = csr_ch.data;
            sdspi_pkg::CSR_HCS:         cfg_in.hcs         = csr_ch.data[0];
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.poll_limit  <= sdspi_pkg::POLL_LIMIT_RESET;
         cfg_ff.retry_limit <= sdspi_pkg::RETRY_LIMIT_RESET;
         cfg_ff.hcs         <= sdspi_pkg::HCS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

[sv/sdspi_core.sv]
// Sequencer state and next-byte logic of the SD card SPI init sequencer.
// Depends on sdspi_pkg.
`default_nettype none

module sdspi_core #(
   parameter int PREAMBLE_BYTES = sdspi_pkg::PREAMBLE_BYTES_DEFAULT,
   parameter int RESPONSE_DEPTH = sdspi_pkg::RESPONSE_DEPTH_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             step,
   input  wire logic             start_request,
   input  wire logic [7:0]       rx_byte,
   input  sdspi_pkg::cfg_type    cfg,
   output sdspi_pkg::result_type result
);

   localparam int BC_W = $clog2(PREAMBLE_BYTES);
   localparam int RI_W = $clog2(RESPONSE_DEPTH);

   sdspi_pkg::seq_state_type state_ff, state_in;
   sdspi_pkg::cmd_slot_type  slot_ff, slot_in;
   logic [BC_W-1:0]          bc_ff, bc_in;
   logic [7:0]               poll_ff, poll_in;
   logic [7:0]               retry_ff, retry_in;
   logic [7:0]               resp_ff [RESPONSE_DEPTH];

   logic [BC_W:0]            bc_inc;
   logic [8:0]               poll_inc;
   logic [8:0]               retry_inc;
   logic                     resp_we;
   logic [RI_W-1:0]          resp_wi;
   logic                     start_cmd;
   sdspi_pkg::cmd_slot_type  next_slot;
   logic                     do_finish;
   logic [2:0]               fin_status;
   logic [7:0]               fin_off;
   logic                     poll_more;
   logic [7:0]               r1;

   always_comb begin
      state_in   = state_ff;
      slot_in    = slot_ff;
      bc_in      = bc_ff;
      poll_in    = poll_ff;
      retry_in   = retry_ff;
      resp_we    = 1'b0;
      resp_wi    = '0;
      start_cmd  = 1'b0;
      next_slot  = sdspi_pkg::SLOT_CMD0;
      do_finish  = 1'b0;
      fin_status = sdspi_pkg::STATUS_OK;
      fin_off    = 8'h00;
      poll_more  = 1'b0;
      r1         = resp_ff[0];
      bc_inc     = {1'b0, bc_ff} + (BC_W+1)'(1);
      poll_inc   = {1'b0, poll_ff} + 9'd1;
      retry_inc  = {1'b0, retry_ff} + 9'd1;

      result.tx_byte            = sdspi_pkg::BYTE_FILL;
      result.tx_enable          = 1'b0;
      result.chip_select_n      = 1'b1;
      result.finished           = 1'b0;
      result.status             = sdspi_pkg::STATUS_OK;
      result.offending_response = 8'h00;

      unique case (state_ff)
         sdspi_pkg::ST_IDLE: begin
            if (start_request) begin
               state_in         = sdspi_pkg::ST_PRE;
               bc_in            = '0;
               result.tx_enable = 1'b1;
            end
         end
         sdspi_pkg::ST_PRE: begin
            if (bc_inc >= (BC_W+1)'(PREAMBLE_BYTES)) begin
               start_cmd = 1'b1;
               next_slot = sdspi_pkg::SLOT_CMD0;
            end else begin
               bc_in            = bc_inc[BC_W-1:0];
               result.tx_enable = 1'b1;
            end
         end
         sdspi_pkg::ST_SEND: begin
            if (bc_ff < BC_W'(sdspi_pkg::FRAME_LAST)) begin
               bc_in                = bc_inc[BC_W-1:0];
               result.tx_byte       = sdspi_pkg::frame_byte(slot_ff,
                                         bc_inc[sdspi_pkg::FRAME_IDX_W-1:0], cfg.hcs);
               result.tx_enable     = 1'b1;
               result.chip_select_n = 1'b0;
            end else begin
               state_in  = sdspi_pkg::ST_POLL;
               poll_in   = 8'h00;
               poll_more = 1'b1;
            end
         end
         sdspi_pkg::ST_POLL: begin
            if (rx_byte[7]) begin
               // Still filler: keep polling until the limit runs out.
               if (poll_inc >= {1'b0, cfg.poll_limit}) begin
                  do_finish  = 1'b1;
                  fin_status = sdspi_pkg::STATUS_TIMEOUT;
               end else begin
                  poll_in   = poll_inc[7:0];
                  poll_more = 1'b1;
               end
            end else if (rx_byte > sdspi_pkg::R1_IDLE) begin
               do_finish  = 1'b1;
               fin_status = sdspi_pkg::STATUS_BAD_R1;
               fin_off    = rx_byte;
            end else begin
               resp_we = 1'b1;
               resp_wi = '0;
               if (sdspi_pkg::cmd_len(slot_ff) > 3'd1) begin
                  state_in = sdspi_pkg::ST_COLLECT;
                  bc_in    = BC_W'(1);
               end else begin
                  state_in = sdspi_pkg::ST_TRAIL;
               end
               poll_more = 1'b1;
            end
         end
         sdspi_pkg::ST_COLLECT: begin
            resp_we = (bc_ff < BC_W'(RESPONSE_DEPTH));
            resp_wi = bc_ff[RI_W-1:0];
            if (bc_inc < (BC_W+1)'(sdspi_pkg::cmd_len(slot_ff))) begin
               bc_in = bc_inc[BC_W-1:0];
            end else begin
               state_in = sdspi_pkg::ST_TRAIL;
            end
            poll_more = 1'b1;
         end
         sdspi_pkg::ST_TRAIL: begin
            // The trailing byte is done; judge the stored response.
            unique case (slot_ff)
               sdspi_pkg::SLOT_CMD0: begin
                  if (r1 != sdspi_pkg::R1_IDLE) begin
                     do_finish  = 1'b1;
                     fin_status = sdspi_pkg::STATUS_BAD_R1;
                     fin_off    = r1;
                  end else begin
                     start_cmd = 1'b1;
                     next_slot = sdspi_pkg::SLOT_CMD8;
                  end
               end
               sdspi_pkg::SLOT_CMD8: begin
                  if (r1 != sdspi_pkg::R1_IDLE) begin
                     do_finish  = 1'b1;
                     fin_status = sdspi_pkg::STATUS_BAD_R1;
                     fin_off    = r1;
                  end else if (resp_ff[3] != sdspi_pkg::VOLT_ACCEPT) begin
                     do_finish  = 1'b1;
                     fin_status = sdspi_pkg::STATUS_VOLTAGE;
                  end else begin
                     start_cmd = 1'b1;
                     next_slot = sdspi_pkg::SLOT_CMD58_OCR;
                  end
               end
               sdspi_pkg::SLOT_CMD58_OCR: begin
                  if (r1 != sdspi_pkg::R1_IDLE) begin
                     do_finish  = 1'b1;
                     fin_status = sdspi_pkg::STATUS_BAD_R1;
                     fin_off    = r1;
                  end else if ((resp_ff[2] & sdspi_pkg::OCR_VOLT_MASK)
                               != sdspi_pkg::OCR_VOLT_MASK) begin
                     do_finish  = 1'b1;
                     fin_status = sdspi_pkg::STATUS_VOLTAGE;
                  end else begin
                     retry_in  = 8'h00;
                     start_cmd = 1'b1;
                     next_slot = sdspi_pkg::SLOT_CMD55;
                  end
               end
               sdspi_pkg::SLOT_CMD55: begin
                  start_cmd = 1'b1;
                  next_slot = sdspi_pkg::SLOT_ACMD41;
               end
               sdspi_pkg::SLOT_ACMD41: begin
                  if (r1 == sdspi_pkg::R1_READY) begin
                     start_cmd = 1'b1;
                     next_slot = sdspi_pkg::SLOT_CMD58_LAST;
                  end else if (retry_inc >= {1'b0, cfg.retry_limit}) begin
                     do_finish  = 1'b1;
                     fin_status = sdspi_pkg::STATUS_STUCK;
                  end else begin
                     retry_in  = retry_inc[7:0];
                     start_cmd = 1'b1;
                     next_slot = sdspi_pkg::SLOT_CMD55;
                  end
               end
               sdspi_pkg::SLOT_CMD58_LAST: begin
                  do_finish = 1'b1;
                  if (r1 != sdspi_pkg::R1_READY) begin
                     fin_status = sdspi_pkg::STATUS_IDLE_END;
                  end else if ((resp_ff[1] & sdspi_pkg::OCR_CCS_MASK)
                               != sdspi_pkg::OCR_CCS_MASK) begin
                     fin_status = sdspi_pkg::STATUS_CAPACITY;
                  end else begin
                     fin_status = sdspi_pkg::STATUS_OK;
                  end
               end
               default: begin
                  state_in = sdspi_pkg::ST_IDLE;
               end
            endcase
         end
         default: begin
            state_in = sdspi_pkg::ST_IDLE;
         end
      endcase

      if (poll_more) begin
         result.tx_enable     = 1'b1;
         result.chip_select_n = 1'b0;
      end
      if (start_cmd) begin
         state_in             = sdspi_pkg::ST_SEND;
         slot_in              = next_slot;
         bc_in                = '0;
         result.tx_byte       = sdspi_pkg::frame_byte(next_slot,
                                   sdspi_pkg::FRAME_IDX_W'(0), cfg.hcs);
         result.tx_enable     = 1'b1;
         result.chip_select_n = 1'b0;
      end
      if (do_finish) begin
         state_in                  = sdspi_pkg::ST_IDLE;
         result.finished           = 1'b1;
         result.status             = fin_status;
         result.offending_response = fin_off;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sdspi_pkg::ST_IDLE;
         slot_ff  <= sdspi_pkg::SLOT_CMD0;
         bc_ff    <= '0;
         poll_ff  <= 8'h00;
         retry_ff <= 8'h00;
      end else if (step) begin
         state_ff <= state_in;
         slot_ff  <= slot_in;
         bc_ff    <= bc_in;
         poll_ff  <= poll_in;
         retry_ff <= retry_in;
      end
   end

   // Response bytes carry no reset; every check reads bytes of the current response.
   always_ff @(posedge clock) begin
      if (step && resp_we) begin
         resp_ff[resp_wi] <= rx_byte;
      end
   end

endmodule

`default_nettype wire

[sv/sd_spi_init_sequencer.sv]
// Top level of the SD card SPI-mode init sequencer: input register, sequencer
// core, result register and configuration registers. Depends on sdspi_pkg,
// sdspi_if.sv, sdspi_cfg, sdspi_core and sd_spi_init_sequencer_assert.svh.
//
// Usage: each item on req_ch reports one finished SPI byte exchange (rx_byte is
// the byte the card returned) and may carry start_request, which launches the
// init sequence when the sequencer is idle. For every item the block returns
// exactly one item on rsp_ch naming the next exchange: tx_byte, tx_enable and
// chip_select_n, plus finished, status and offending_response on the item
// where the sequence ends. The sequence is ten (PREAMBLE_BYTES) 0xFF bytes with
// the card deselected, CMD0, CMD8, CMD58, CMD55 plus ACMD41 rounds, and a final
// CMD58.
// An accepted item waits in the input register; all the per-item work is a single
// combinational pass through the core into the result register, which drives rsp_ch.
// Throughput is one item per cycle while rsp_ch.ready stays high.
// Stalls: while rsp_ch.ready is low the result register holds its item and the
// input register still takes one more item; req_ch.ready drops only when both
// are full. csr_ch is always ready; write it only while the sequencer is idle.
// Reset (synchronous, active high) empties both registers, returns the
// sequencer to idle and loads the register defaults (poll and retry limits of
// 100, high-capacity request set).
`default_nettype none
`include "sd_spi_init_sequencer_assert.svh"

module sd_spi_init_sequencer #(
   parameter int PREAMBLE_BYTES = sdspi_pkg::PREAMBLE_BYTES_DEFAULT,
   parameter int RESPONSE_DEPTH = sdspi_pkg::RESPONSE_DEPTH_DEFAULT
) (
   input wire logic     clock,
   input wire logic     reset,
   sdspi_req_if.sink    req_ch,
   sdspi_rsp_if.source  rsp_ch,
   sdspi_csr_if.sink    csr_ch
);

   // Input register: one accepted item waiting for the core.
   logic       in_valid_ff, in_valid_in;
   logic       in_start_ff;
   logic [7:0] in_rx_ff;

   // Result register: one finished item waiting for the receiver.
   logic                  out_valid_ff, out_valid_in;
   sdspi_pkg::result_type out_res_ff;

   sdspi_pkg::cfg_type    cfg;
   sdspi_pkg::result_type core_res;
   logic                  advance;
   logic                  req_take;
   logic                  rsp_take;

   // The core consumes the held item whenever the result register is free or
   // being emptied in the same cycle.
   assign advance  = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_take = req_ch.valid && req_ch.ready;
   assign rsp_take = out_valid_ff && rsp_ch.ready;

   assign req_ch.ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_start_ff <= req_ch.start_request;
         in_rx_ff    <= req_ch.rx_byte;
      end
      if (advance) begin
         out_res_ff <= core_res;
      end
   end

   sdspi_cfg u_cfg (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   sdspi_core #(
      .PREAMBLE_BYTES (PREAMBLE_BYTES),
      .RESPONSE_DEPTH (RESPONSE_DEPTH)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .step          (advance),
      .start_request (in_start_ff),
      .rx_byte       (in_rx_ff),
      .cfg           (cfg),
      .result        (core_res)
   );

   assign rsp_ch.valid              = out_valid_ff;
   assign rsp_ch.tx_byte            = out_res_ff.tx_byte;
   assign rsp_ch.tx_enable          = out_res_ff.tx_enable;
   assign rsp_ch.chip_select_n      = out_res_ff.chip_select_n;
   assign rsp_ch.finished           = out_res_ff.finished;
   assign rsp_ch.status             = out_res_ff.status;
   assign rsp_ch.offending_response = out_res_ff.offending_response;

   // An ending item always releases the card and stops the byte exchanges.
   `SDSPI_ASSERT_NOW(a_end_releases, clock, reset, out_valid_ff && out_res_ff.finished, !out_res_ff.tx_enable && out_res_ff.chip_select_n)

   // No exchange requested means the filler byte is shown.
   `SDSPI_ASSERT_NOW(a_idle_fill, clock, reset, out_valid_ff && !out_res_ff.tx_enable, out_res_ff.tx_byte == sdspi_pkg::BYTE_FILL)

   // Status and offending byte are only reported on the ending item.
   `SDSPI_ASSERT_NOW(a_status_on_end, clock, reset, out_valid_ff && !out_res_ff.finished, (out_res_ff.status == sdspi_pkg::STATUS_OK) && (out_res_ff.offending_response == 8'h00))

   // A held input item is neither lost nor overwritten while the core waits.
   `SDSPI_ASSERT_NEXT(a_in_hold, clock, reset, in_valid_ff && !advance, in_valid_ff && $stable(in_rx_ff) && $stable(in_start_ff))

endmodule

`default_nettype wire

[tb/sd_spi_init_sequencer_tb.sv]
// Self-checking testbench for the SD card SPI-mode init sequencer.
// A behavioral card answers every byte exchange, and an in-bench predictor checks each result.
// Depends on sdspi_pkg, sdspi_if.sv and the sequencer RTL.

module sd_spi_init_sequencer_tb;
   import sdspi_pkg::*;

   localparam int PREAMBLE_LEN = PREAMBLE_BYTES_DEFAULT;
   localparam int RESP_DEPTH = RESPONSE_DEPTH_DEFAULT;
   localparam int LONG_RESP_LEN = 5;
   localparam int DRAIN_CYCLES = 8;
   localparam int MAX_SHOWN_ERRORS = 30;

   // SD command indexes; the start and transmission bits come from CMD_START.
   localparam logic [5:0] IDX_GO_IDLE = 6'd0;
   localparam logic [5:0] IDX_SEND_IF_COND = 6'd8;
   localparam logic [5:0] IDX_APP_CMD = 6'd55;
   localparam logic [5:0] IDX_SD_SEND_OP_COND = 6'd41;
   localparam logic [5:0] IDX_READ_OCR = 6'd58;

   // Ways in which the behavioral card can misbehave during one init sequence.
   typedef enum {
      FAULT_NONE,
      FAULT_BAD_R1,
      FAULT_EARLY_READY,
      FAULT_VOLTAGE,
      FAULT_STUCK_IDLE,
      FAULT_IDLE_AT_END,
      FAULT_NO_CCS,
      FAULT_SILENT
   } card_fault_type;

   typedef enum {STALL_NONE, STALL_RANDOM, STALL_PERIODIC, STALL_HEAVY} stall_pattern_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sdspi_req_if req_ch ();
   sdspi_rsp_if rsp_ch ();
   sdspi_csr_if csr_ch ();

   sd_spi_init_sequencer #(
      .PREAMBLE_BYTES(PREAMBLE_LEN),
      .RESPONSE_DEPTH(RESP_DEPTH)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .csr_ch(csr_ch)
   );

   always #2 clock = ~clock;

   // Register settings as the sequencer should hold them.
   cfg_type cfg_shadow;

   // Predicted sequencer state: where it is in the init flow and what it has
   // collected of the current response.
   seq_state_type seq_phase;
   cmd_slot_type seq_slot;
   int unsigned seq_byte_idx;
   int unsigned seq_poll_count;
   int unsigned seq_retry_count;
   logic [7:0] seq_resp [RESP_DEPTH];

   // Next-exchange results still owed by the sequencer, oldest first.
   result_type pending_exchanges [$];

   // Behavioral card plan for the sequence in progress.
   card_fault_type fault;
   cmd_slot_type fault_slot;
   int unsigned busy_pct;
   int unsigned acmd_idle_left;

   // Sender pacing.
   bit gaps_enabled;
   bit sender_parked;
   int unsigned burst_left;

   int unsigned items_sent;
   int unsigned results_seen;
   int unsigned sequences_run;
   int unsigned mismatch_count;
   int unsigned status_tally [8];

   cmd_slot_type slot_menu [6] = '{SLOT_CMD0, SLOT_CMD8, SLOT_CMD58_OCR,
                                   SLOT_CMD55, SLOT_ACMD41, SLOT_CMD58_LAST};
   card_fault_type fault_menu [7] = '{FAULT_BAD_R1, FAULT_EARLY_READY, FAULT_VOLTAGE,
                                      FAULT_STUCK_IDLE, FAULT_IDLE_AT_END, FAULT_NO_CCS,
                                      FAULT_SILENT};
   stall_pattern_type stall_menu [4] = '{STALL_NONE, STALL_RANDOM, STALL_PERIODIC,
                                         STALL_HEAVY};
   int unsigned busy_menu [4] = '{0, 10, 35, 65};

   // ---------------------------------------------------------------------
   // Predictor of the next exchange
   // ---------------------------------------------------------------------

   function automatic result_type make_result(logic [7:0] tx, logic en, logic csn, logic fin,
                                              status_type st, logic [7:0] off);
      result_type r;
      r.tx_byte = tx;
      r.tx_enable = en;
      r.chip_select_n = csn;
      r.finished = fin;
      r.status = st;
      r.offending_response = off;
      return r;
   endfunction

   // Byte idx of the six-byte frame {code, big-endian argument, CRC}.
   function automatic logic [7:0] cmd_frame_byte(cmd_slot_type slot, int unsigned idx);
      logic [47:0] frame;
      logic [5:0] cmd_index;
      logic [31:0] arg;
      logic [7:0] crc;
      arg = '0;
      crc = CRC_OTHER;
      case (slot)
         SLOT_CMD0: begin
            cmd_index = IDX_GO_IDLE;
            crc = CRC_CMD0;
         end
         SLOT_CMD8: begin
            cmd_index = IDX_SEND_IF_COND;
            arg = CMD8_ARG;
            crc = CRC_CMD8;
         end
         SLOT_CMD55: cmd_index = IDX_APP_CMD;
         SLOT_ACMD41: begin
            cmd_index = IDX_SD_SEND_OP_COND;
            if (cfg_shadow.hcs) arg = HCS_ARG;
         end
         default: cmd_index = IDX_READ_OCR;
      endcase
      frame = {CMD_START | {2'b00, cmd_index}, arg, crc};
      return frame[47 - 8 * idx -: 8];
   endfunction

   // Any ending deselects the card, stops exchanges and returns to idle.
   function automatic result_type end_sequence(status_type st, logic [7:0] off);
      seq_phase = ST_IDLE;
      return make_result(BYTE_FILL, 1'b0, 1'b1, 1'b1, st, off);
   endfunction

   function automatic result_type open_command(cmd_slot_type slot);
      seq_phase = ST_SEND;
      seq_slot = slot;
      seq_byte_idx = 0;
      return make_result(cmd_frame_byte(slot, 0), 1'b1, 1'b0, 1'b0, STATUS_OK, 8'h00);
   endfunction

   // Decision after the trailing byte of a response.
   function automatic result_type judge_response();
      logic [7:0] r1;
      r1 = seq_resp[0];
      case (seq_slot)
         SLOT_CMD0: begin
            if (r1 != R1_IDLE) return end_sequence(STATUS_BAD_R1, r1);
            return open_command(SLOT_CMD8);
         end
         SLOT_CMD8: begin
            if (r1 != R1_IDLE) return end_sequence(STATUS_BAD_R1, r1);
            // Only the voltage-accepted byte of the echo matters.
            if (seq_resp[3] != VOLT_ACCEPT) return end_sequence(STATUS_VOLTAGE, 8'h00);
            return open_command(SLOT_CMD58_OCR);
         end
         SLOT_CMD58_OCR: begin
            if (r1 != R1_IDLE) return end_sequence(STATUS_BAD_R1, r1);
            if ((seq_resp[2] & OCR_VOLT_MASK) != OCR_VOLT_MASK)
               return end_sequence(STATUS_VOLTAGE, 8'h00);
            seq_retry_count = 0;
            return open_command(SLOT_CMD55);
         end
         SLOT_CMD55: return open_command(SLOT_ACMD41);
         SLOT_ACMD41: begin
            if (r1 == R1_READY) return open_command(SLOT_CMD58_LAST);
            // A retry limit of zero behaves as one round.
            if (seq_retry_count + 1 >= cfg_shadow.retry_limit)
               return end_sequence(STATUS_STUCK, 8'h00);
            seq_retry_count = (seq_retry_count + 1) & 8'hFF;
            return open_command(SLOT_CMD55);
         end
         default: begin
            if (r1 != R1_READY) return end_sequence(STATUS_IDLE_END, 8'h00);
            if ((seq_resp[1] & OCR_CCS_MASK) != OCR_CCS_MASK)
               return end_sequence(STATUS_CAPACITY, 8'h00);
            return end_sequence(STATUS_OK, 8'h00);
         end
      endcase
   endfunction

   // Advances the predicted state by one accepted exchange and returns the
   // result the sequencer must give for it.
   function automatic result_type predict_exchange(logic start, logic [7:0] rx);
      result_type fill;
      int unsigned resp_len;
      fill = make_result(BYTE_FILL, 1'b1, 1'b0, 1'b0, STATUS_OK, 8'h00);
      resp_len = (seq_slot == SLOT_CMD8 || seq_slot == SLOT_CMD58_OCR ||
                  seq_slot == SLOT_CMD58_LAST) ? LONG_RESP_LEN : 1;
      case (seq_phase)
         ST_IDLE: begin
            if (start) begin
               seq_phase = ST_PRE;
               seq_byte_idx = 0;
               return make_result(BYTE_FILL, 1'b1, 1'b1, 1'b0, STATUS_OK, 8'h00);
            end
            return make_result(BYTE_FILL, 1'b0, 1'b1, 1'b0, STATUS_OK, 8'h00);
         end
         ST_PRE: begin
            if (seq_byte_idx + 1 >= PREAMBLE_LEN) return open_command(SLOT_CMD0);
            seq_byte_idx++;
            return make_result(BYTE_FILL, 1'b1, 1'b1, 1'b0, STATUS_OK, 8'h00);
         end
         ST_SEND: begin
            if (seq_byte_idx < FRAME_LAST) begin
               seq_byte_idx++;
               return make_result(cmd_frame_byte(seq_slot, seq_byte_idx), 1'b1, 1'b0, 1'b0,
                                  STATUS_OK, 8'h00);
            end
            seq_phase = ST_POLL;
            seq_poll_count = 0;
            return fill;
         end
         ST_POLL: begin
            if (rx[7]) begin
               if (seq_poll_count + 1 >= cfg_shadow.poll_limit)
                  return end_sequence(STATUS_TIMEOUT, 8'h00);
               seq_poll_count = (seq_poll_count + 1) & 8'hFF;
               return fill;
            end
            // Any R1 other than ready or idle ends at once, before the trailer.
            if (rx > R1_IDLE) return end_sequence(STATUS_BAD_R1, rx);
            seq_resp[0] = rx;
            if (resp_len > 1) begin
               seq_phase = ST_COLLECT;
               seq_byte_idx = 1;
            end else begin
               seq_phase = ST_TRAIL;
            end
            return fill;
         end
         ST_COLLECT: begin
            if (seq_byte_idx < RESP_DEPTH) seq_resp[seq_byte_idx] = rx;
            if (seq_byte_idx + 1 < resp_len) seq_byte_idx++;
            else seq_phase = ST_TRAIL;
            return fill;
         end
         default: return judge_response();
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Behavioral card
   // ---------------------------------------------------------------------

   function automatic void plan_card(card_fault_type f);
      fault = f;
      busy_pct = busy_menu[$urandom_range(3)];
      acmd_idle_left = $urandom_range(3);
      case (f)
         FAULT_BAD_R1: fault_slot = slot_menu[$urandom_range(5)];
         FAULT_EARLY_READY: fault_slot = slot_menu[$urandom_range(2)];
         FAULT_VOLTAGE: fault_slot = $urandom_range(1) ? SLOT_CMD8 : SLOT_CMD58_OCR;
         default: fault_slot = SLOT_CMD0;
      endcase
   endfunction

   // Most sequences are healthy; faults that would take very long under the
   // current limits are replaced by a healthy card.
   function automatic card_fault_type pick_fault();
      card_fault_type f;
      f = FAULT_NONE;
      if ($urandom_range(99) >= 55) f = fault_menu[$urandom_range(6)];
      if (f == FAULT_STUCK_IDLE && cfg_shadow.retry_limit > 8) f = FAULT_NONE;
      if (f == FAULT_SILENT && cfg_shadow.poll_limit > 100) f = FAULT_NONE;
      return f;
   endfunction

   // The byte the card returns in the exchange that the sequencer asked for
   // last. It reads the predicted state, which is current because every item
   // is predicted as soon as it is accepted.
   function automatic logic [7:0] card_reply();
      logic [7:0] noise;
      logic on_target;
      noise = 8'($urandom);
      on_target = (seq_slot == fault_slot);
      case (seq_phase)
         ST_POLL: begin
            if (fault == FAULT_SILENT || $urandom_range(99) < busy_pct) return noise | 8'h80;
            if (fault == FAULT_BAD_R1 && on_target) return 8'($urandom_range(2, 127));
            case (seq_slot)
               SLOT_CMD55: return $urandom_range(1) ? R1_IDLE : R1_READY;
               SLOT_ACMD41: begin
                  if (fault == FAULT_STUCK_IDLE || acmd_idle_left > 0) begin
                     if (acmd_idle_left > 0) acmd_idle_left--;
                     return R1_IDLE;
                  end
                  return R1_READY;
               end
               SLOT_CMD58_LAST: return (fault == FAULT_IDLE_AT_END) ? R1_IDLE : R1_READY;
               default: return (fault == FAULT_EARLY_READY && on_target) ? R1_READY : R1_IDLE;
            endcase
         end
         ST_COLLECT: begin
            if (seq_slot == SLOT_CMD8 && seq_byte_idx == 3) begin
               if (fault == FAULT_VOLTAGE && on_target)
                  return (noise == VOLT_ACCEPT) ? ~noise : noise;
               return VOLT_ACCEPT;
            end
            if (seq_slot == SLOT_CMD8 && seq_byte_idx == 4) return CMD8_ARG[7:0];
            if (seq_slot == SLOT_CMD58_OCR && seq_byte_idx == 2) begin
               if (fault == FAULT_VOLTAGE && on_target)
                  return noise & ~(8'h10 << $urandom_range(1));
               return noise | OCR_VOLT_MASK;
            end
            if (seq_slot == SLOT_CMD58_LAST && seq_byte_idx == 1) begin
               if (fault == FAULT_NO_CCS) return noise & ~(8'h40 << $urandom_range(1));
               return noise | OCR_CCS_MASK;
            end
            return noise;
         end
         default: return noise;
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Driving
   // ---------------------------------------------------------------------

   // Sends one exchange item and records the result it must produce. The
   // sender works in bursts when gaps are enabled; between bursts valid drops.
   task automatic send_exchange(input logic start, input logic [7:0] rx);
      if (gaps_enabled && burst_left == 0) begin
         if (!sender_parked) req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 24);
      end
      if (burst_left > 0) burst_left--;
      req_ch.valid <= 1'b1;
      req_ch.start_request <= start;
      req_ch.rx_byte <= rx;
      sender_parked = 1'b0;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      pending_exchanges.push_back(predict_exchange(start, rx));
      items_sent++;
   endtask

   // Holds the sender off until every predicted result has come back.
   task automatic await_all_results();
      if (!sender_parked) begin
         req_ch.valid <= 1'b0;
         sender_parked = 1'b1;
      end
      do @(posedge clock); while (pending_exchanges.size() != 0);
   endtask

   // Writes all three registers back to back once the sequencer has drained.
   task automatic load_settings(input logic [7:0] poll_limit, input logic [7:0] retry_limit,
                                input logic hcs);
      logic [7:0] value;
      csr_index_type idx;
      await_all_results();
      repeat (2) @(posedge clock);
      for (int i = 0; i < 3; i++) begin
         case (i)
            0: begin
               idx = CSR_POLL_LIMIT;
               value = poll_limit;
            end
            1: begin
               idx = CSR_RETRY_LIMIT;
               value = retry_limit;
            end
            default: begin
               idx = CSR_HCS;
               value = {7'b0, hcs};
            end
         endcase
         csr_ch.valid <= 1'b1;
         csr_ch.index <= idx;
         csr_ch.data <= value;
         do @(posedge clock); while (csr_ch.ready !== 1'b1);
         case (idx)
            CSR_POLL_LIMIT: cfg_shadow.poll_limit = value;
            CSR_RETRY_LIMIT: cfg_shadow.retry_limit = value;
            default: cfg_shadow.hcs = value[0];
         endcase
      end
      csr_ch.valid <= 1'b0;
   endtask

   // One full init sequence against a card with the given fault. A few idle
   // items may come first; start is set at random while the sequence runs,
   // which the sequencer must ignore.
   task automatic run_init_sequence(input card_fault_type f);
      plan_card(f);
      repeat ($urandom_range(0, 2)) send_exchange(1'b0, 8'($urandom));
      send_exchange(1'b1, 8'($urandom));
      while (seq_phase != ST_IDLE) send_exchange(1'($urandom), card_reply());
      sequences_run++;
   endtask

   task automatic run_random_sequences(input int unsigned budget);
      int unsigned first;
      first = items_sent;
      while (items_sent - first < budget) begin
         run_init_sequence(pick_fault());
         if ($urandom_range(99) < 15) await_all_results();
      end
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Idle items with start low give a quiet result whatever rx_byte holds.
   task automatic test_idle_steps();
      send_exchange(1'b0, 8'h00);
      send_exchange(1'b0, 8'hFF);
      send_exchange(1'b0, 8'($urandom));
   endtask

   // Preamble and CMD0 with start held high throughout, one busy poll, then
   // an R1 with an error bit set, which must end the sequence at once.
   task automatic test_bad_r1_on_go_idle();
      int unsigned n;
      n = 0;
      send_exchange(1'b1, 8'h00);
      while (seq_phase != ST_POLL) begin
         send_exchange(1'b1, n[0] ? 8'hFF : 8'h00);
         n++;
      end
      send_exchange(1'b0, 8'h80);
      send_exchange(1'b0, 8'h7F);
      await_all_results();
   endtask

   task automatic test_default_settings();
      gaps_enabled = 1'b1;
      run_random_sequences(140);
   endtask

   // Every kind of card fault once, with short limits so stuck cards and
   // silent cards end quickly.
   task automatic test_fault_tour();
      load_settings(8'd6, 8'd3, 1'b0);
      run_init_sequence(FAULT_NONE);
      foreach (fault_menu[i]) run_init_sequence(fault_menu[i]);
   endtask

   task automatic test_low_extremes();
      load_settings(8'd1, 8'd1, 1'b0);
      run_random_sequences(70);
   endtask

   // Back-to-back items with no sender gaps at the largest limits.
   task automatic test_high_extremes();
      load_settings(8'd255, 8'd255, 1'b1);
      gaps_enabled = 1'b0;
      run_random_sequences(120);
      gaps_enabled = 1'b1;
   endtask

   // Zero limits must act as a single poll and a single round.
   task automatic test_zero_limits();
      load_settings(8'd0, 8'd0, 1'b1);
      run_random_sequences(50);
   endtask

   task automatic test_random_settings();
      repeat (2) begin
         load_settings(8'($urandom_range(2, 30)), 8'($urandom_range(2, 8)),
                       1'($urandom_range(1)));
         run_random_sequences(90);
      end
   endtask

   // ---------------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------------

   function automatic void report_mismatch(string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_SHOWN_ERRORS)
         $display("ERROR at result %0d: %s", results_seen, msg);
   endfunction

   function automatic void compare_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want) report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
   endfunction

   // Every accepted result item is held against the oldest prediction.
   always @(posedge clock) begin : check_results
      result_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         results_seen++;
         if (pending_exchanges.size() == 0) begin
            report_mismatch("result item arrived with nothing expected");
         end else begin
            want = pending_exchanges.pop_front();
            compare_field("tx_byte", rsp_ch.tx_byte, want.tx_byte);
            compare_field("tx_enable", rsp_ch.tx_enable, want.tx_enable);
            compare_field("chip_select_n", rsp_ch.chip_select_n, want.chip_select_n);
            compare_field("finished", rsp_ch.finished, want.finished);
            compare_field("status", rsp_ch.status, want.status);
            compare_field("offending_response", rsp_ch.offending_response,
                          want.offending_response);
            if (want.finished) status_tally[want.status]++;
         end
      end
   end

   // The result side takes items in stretches of its own: always ready,
   // randomly ready, a fixed duty cycle, or rarely ready.
   initial begin : receiver_pattern
      stall_pattern_type pattern;
      int unsigned pattern_left;
      int unsigned tick;
      rsp_ch.ready <= 1'b0;
      pattern = STALL_NONE;
      pattern_left = 50;
      tick = 0;
      forever begin
         @(posedge clock);
         tick++;
         if (pattern_left == 0) begin
            pattern = stall_menu[$urandom_range(3)];
            pattern_left = $urandom_range(40, 200);
         end else begin
            pattern_left--;
         end
         case (pattern)
            STALL_NONE: rsp_ch.ready <= 1'b1;
            STALL_RANDOM: rsp_ch.ready <= ($urandom_range(99) < 60);
            STALL_PERIODIC: rsp_ch.ready <= ((tick % 5) < 3);
            default: rsp_ch.ready <= ($urandom_range(15) == 0);
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------

   initial begin
      req_ch.valid <= 1'b0;
      req_ch.start_request <= 1'b0;
      req_ch.rx_byte <= 8'h00;
      csr_ch.valid <= 1'b0;
      csr_ch.index <= CSR_POLL_LIMIT;
      csr_ch.data <= 8'h00;
      cfg_shadow.poll_limit = POLL_LIMIT_RESET;
      cfg_shadow.retry_limit = RETRY_LIMIT_RESET;
      cfg_shadow.hcs = HCS_RESET;
      seq_phase = ST_IDLE;
      seq_slot = SLOT_CMD0;
      seq_byte_idx = 0;
      seq_poll_count = 0;
      seq_retry_count = 0;
      foreach (seq_resp[i]) seq_resp[i] = 8'h00;
      gaps_enabled = 1'b1;
      sender_parked = 1'b1;
      burst_left = 0;
      plan_card(FAULT_NONE);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // The first tests run on the reset values of the registers.
      test_idle_steps();
      test_bad_r1_on_go_idle();
      test_default_settings();
      test_fault_tour();
      test_low_extremes();
      test_high_extremes();
      test_zero_limits();
      test_random_settings();

      await_all_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_exchanges.size() != 0)
         report_mismatch($sformatf("%0d result items never arrived", pending_exchanges.size()));

      $display("Ran %0d exchange items through %0d init sequences under seven register settings; %0d results checked.",
               items_sent, sequences_run, results_seen);
      $display("Endings seen: ok %0d, timeout %0d, bad R1 %0d, voltage %0d, stuck %0d, idle at end %0d, capacity %0d",
               status_tally[STATUS_OK], status_tally[STATUS_TIMEOUT],
               status_tally[STATUS_BAD_R1], status_tally[STATUS_VOLTAGE],
               status_tally[STATUS_STUCK], status_tally[STATUS_IDLE_END],
               status_tally[STATUS_CAPACITY]);
      if (mismatch_count == 0) begin
         $display("sd_spi_init_sequencer verification clean");
      end else begin
         $display("sd_spi_init_sequencer verification failed");
      end
      $finish;
   end

   // Watchdog. A correct run ends well before it, even with the heaviest stalls and gaps.
   initial begin
      #2_000_000;
      $display("sd_spi_init_sequencer verification failed");
      $finish;
   end

endmodule

[files.f]
+incdir+sv
sv/sdspi_pkg.sv
sv/sdspi_if.sv
sv/sdspi_cfg.sv
sv/sdspi_core.sv
sv/sd_spi_init_sequencer.sv
tb/sd_spi_init_sequencer_tb.sv
